// ----- sv/dcal_pkg.sv -----
// Shared types and constants for the DRAM cache access lookup block.
// Holds the field widths, input kind and page class codes, the controller state
// type and the command/status structs between controller and datapath.
`default_nettype none

package dcal_pkg;

    localparam int KIND_W     = 2;
    localparam int ADDR_W     = 16;
    localparam int PNUM_W     = 10;
    localparam int CLASS_W    = 2;
    localparam int WAY_W      = 2;
    localparam int RES_W      = 2;
    localparam int CNT_W      = 32;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 136;
    localparam int PLACE_W    = ADDR_W + 1;
    localparam int TAG_ENT_W  = ADDR_W + 2;

    localparam logic [KIND_W-1:0] KIND_ACCESS      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET_PAGE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR_COUNT = 2'd2;

    localparam logic [CLASS_W-1:0] CLASS_COLD    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_UNIFORM = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_BLOAT   = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV_WAIT,
        ST_PAGE_WRITE,
        ST_HUGE_A,
        ST_HUGE_B,
        ST_PAGE_READ,
        ST_CLASSIFY,
        ST_PLACE,
        ST_SLOT_A,
        ST_SLOT_B,
        ST_TAG_READ,
        ST_TAG_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic clear_counters;
        logic page_write;
        logic page_read;
        logic classify;
        logic place_a;
        logic place_b;
        logic tag_read;
        logic tag_check;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic                clear_last;
        logic [KIND_W-1:0]   kind;
        logic                direct;
        logic [CLASS_W-1:0]  page_class;
    } status_t;

endpackage

`default_nettype wire

// ----- sv/dcal_divc.sv -----
// Division of an unsigned value by a fixed constant, two pipeline stages.
// Multiplies by a rounded-up reciprocal, then forms the remainder from the
// quotient. Stand-alone; uses no package.
`default_nettype none

module dcal_divc #(
    parameter int W       = 16,
    parameter int DIVISOR = 3
) (
    input  wire logic         aclk,
    input  wire logic [W-1:0] x,
    output logic [W-1:0]      quot,
    output logic [W-1:0]      rem
);

    localparam int L  = $clog2(DIVISOR);
    localparam int S  = W + L;
    localparam int MW = W + 2;
    localparam int PW = S + W;
    localparam int DW = $clog2(DIVISOR + 1);
    localparam longint unsigned MAGIC = ((64'd1 << S) + DIVISOR - 1) / DIVISOR;
    localparam logic [MW-1:0] M     = MW'(MAGIC);
    localparam logic [DW-1:0] DIV_C = DW'(DIVISOR);

    logic [PW-1:0]   prod_reg;
    logic [W-1:0]    x_reg;
    logic [W-1:0]    quot_reg;
    logic [W-1:0]    rem_reg;
    logic [W-1:0]    q;
    logic [W+DW-1:0] qd;

    // With S = W + ceil(log2 D) the rounding error of the reciprocal stays
    // below one part in D for every W-bit dividend, so the floor is exact.
    // The quotient is below 2^W, so the product never reaches bit S + W.
    assign q  = prod_reg[S +: W];
    assign qd = (W+DW)'(q) * (W+DW)'(DIV_C);

    always_ff @(posedge aclk) begin
        prod_reg <= PW'(x) * PW'(M);
        x_reg    <= x;
        quot_reg <= q;
        rem_reg  <= x_reg - qd[W-1:0];
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ----- sv/dcal_ctrl.sv -----
// Controller state machine of the DRAM cache access lookup block.
// Sequences the clearing pass, each item's steps and the output handshake;
// depends on dcal_pkg.
`default_nettype none

module dcal_ctrl
    import dcal_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_axis_tvalid,
    output logic         s_axis_tready,
    output logic         m_axis_tvalid,
    input  wire logic    m_axis_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (status.kind == KIND_ACCESS || status.kind == KIND_SET_PAGE) begin
                    state_next = ST_DIV_WAIT;
                end else begin
                    cmd.clear_counters = (status.kind == KIND_CLEAR_COUNT);
                    state_next         = ST_DONE;
                end
            end
            ST_DIV_WAIT: begin
                if (status.kind == KIND_SET_PAGE) begin
                    state_next = ST_PAGE_WRITE;
                end else if (status.direct) begin
                    state_next = ST_TAG_READ;
                end else begin
                    state_next = ST_HUGE_A;
                end
            end
            ST_PAGE_WRITE: begin
                cmd.page_write = 1'b1;
                state_next     = ST_DONE;
            end
            ST_HUGE_A: state_next = ST_HUGE_B;
            ST_HUGE_B: state_next = ST_PAGE_READ;
            ST_PAGE_READ: begin
                cmd.page_read = 1'b1;
                state_next    = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                cmd.classify = 1'b1;
                cmd.place_a  = 1'b1;
                if (status.page_class == CLASS_BLOAT) begin
                    state_next = ST_PLACE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PLACE: begin
                cmd.place_b = 1'b1;
                state_next  = ST_SLOT_A;
            end
            ST_SLOT_A: state_next = ST_SLOT_B;
            ST_SLOT_B: state_next = ST_TAG_READ;
            ST_TAG_READ: begin
                cmd.tag_read = 1'b1;
                state_next   = ST_TAG_CHECK;
            end
            ST_TAG_CHECK: begin
                cmd.tag_check = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;

endmodule

`default_nettype wire

// ----- sv/dcal_datapath.sv -----
// Datapath of the DRAM cache access lookup block: item registers, constant
// dividers, tag store, page table, coverage counters and the output register.
// Depends on dcal_pkg and dcal_divc.
`default_nettype none

module dcal_datapath
    import dcal_pkg::*;
#(
    parameter int TAG_SLOTS       = 8192,
    parameter int BLOCKS_PER_HUGE = 64,
    parameter int WAYS            = 4,
    parameter int HUGE_PAGES      = 1024
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    input  wire logic [KIND_W-1:0]   s_axis_tuser,
    input  wire cmd_t                cmd,
    output status_t                  status,
    output logic [M_DATA_W-1:0]      m_axis_tdata
);

    localparam int SETS_RAW = TAG_SLOTS / BLOCKS_PER_HUGE / WAYS;
    localparam int SETS     = (SETS_RAW == 0) ? 1 : SETS_RAW;
    localparam int TS_W     = $clog2(TAG_SLOTS);
    localparam int HP_W     = $clog2(HUGE_PAGES);
    localparam int CLR_N    = (TAG_SLOTS > HUGE_PAGES) ? TAG_SLOTS : HUGE_PAGES;
    localparam int CLR_W    = $clog2(CLR_N);
    localparam logic [WAY_W-1:0] WAY_MOD1 = WAY_W'(1 % WAYS);
    localparam logic [WAY_W-1:0] WAY_MOD2 = WAY_W'(2 % WAYS);
    localparam logic [WAY_W-1:0] WAY_MOD3 = WAY_W'(3 % WAYS);

    // Item registers.
    logic [KIND_W-1:0]  kind_reg;
    logic               wr_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PNUM_W-1:0]  pnum_reg;
    logic [CLASS_W-1:0] class_reg;
    logic [WAY_W-1:0]   way_reg;
    logic               direct_reg;

    // Clearing pass and memories.
    logic [CLR_W-1:0]     clr_reg;
    logic [TAG_ENT_W-1:0] tag_mem [TAG_SLOTS];
    logic [TAG_ENT_W-1:0] tag_rd_reg;
    logic [CLASS_W+WAY_W-1:0] page_mem [HUGE_PAGES];
    logic [CLASS_W+WAY_W-1:0] page_rd_reg;
    logic [TS_W-1:0]      slot_reg;

    // Placement and counters.
    logic [PLACE_W-1:0] sw_reg;
    logic [PLACE_W-1:0] pre_reg;
    logic [RES_W-1:0]   res_reg;
    logic [CNT_W-1:0]   uni_cnt_reg, bloat_cnt_reg, cold_cnt_reg, bhit_cnt_reg;
    logic [M_DATA_W-1:0] out_reg;

    logic [PLACE_W-1:0] ts_x, ts_rem;
    logic [ADDR_W-1:0]  hp, off, hp_x, pn_rem, set_rem;
    logic [HP_W-1:0]    pn;
    logic [TS_W-1:0]    slot;
    logic [WAY_W-1:0]   way_mod;
    logic [CLASS_W-1:0] rd_class;
    logic [WAY_W-1:0]   rd_way;
    logic               hit;
    logic               clr_tag, clr_page;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg  <= s_axis_tuser;
            wr_reg    <= s_axis_tdata[0];
            addr_reg  <= s_axis_tdata[16:1];
            pnum_reg  <= s_axis_tdata[26:17];
            class_reg <= s_axis_tdata[28:27];
            way_reg   <= s_axis_tdata[30:29];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direct_reg <= 1'b1;
            clr_reg    <= '0;
        end else begin
            if (cfg_we) begin
                direct_reg <= cfg_wdata;
            end
            if (cmd.clear_step) begin
                clr_reg <= clr_reg + CLR_W'(1);
            end
        end
    end

    // Constant dividers; the slot divider takes the block address in direct mode and the placed address otherwise.
    assign ts_x = direct_reg ? PLACE_W'(addr_reg) : pre_reg;
    assign hp_x = (kind_reg == KIND_SET_PAGE) ? ADDR_W'(pnum_reg) : hp;

    dcal_divc #(.W(PLACE_W), .DIVISOR(TAG_SLOTS)) u_div_slot (
        .aclk (aclk), .x (ts_x), .quot (), .rem (ts_rem)
    );
    dcal_divc #(.W(ADDR_W), .DIVISOR(BLOCKS_PER_HUGE)) u_div_huge (
        .aclk (aclk), .x (addr_reg), .quot (hp), .rem (off)
    );
    dcal_divc #(.W(ADDR_W), .DIVISOR(HUGE_PAGES)) u_div_page (
        .aclk (aclk), .x (hp_x), .quot (), .rem (pn_rem)
    );
    dcal_divc #(.W(ADDR_W), .DIVISOR(SETS)) u_div_set (
        .aclk (aclk), .x (hp), .quot (), .rem (set_rem)
    );

    assign pn   = pn_rem[HP_W-1:0];
    assign slot = ts_rem[TS_W-1:0];

    always_comb begin
        case (way_reg)
            2'd1:    way_mod = WAY_MOD1;
            2'd2:    way_mod = WAY_MOD2;
            2'd3:    way_mod = WAY_MOD3;
            default: way_mod = '0;
        endcase
    end

    assign clr_tag  = cmd.clear_step && ({1'b0, clr_reg} < (CLR_W+1)'(TAG_SLOTS));
    assign clr_page = cmd.clear_step && ({1'b0, clr_reg} < (CLR_W+1)'(HUGE_PAGES));

    // Page table: class and reduced way per huge page.
    always_ff @(posedge aclk) begin
        if (clr_page) begin
            page_mem[clr_reg[HP_W-1:0]] <= '0;
        end else if (cmd.page_write) begin
            page_mem[pn] <= {class_reg, way_mod};
        end
        if (cmd.page_read) begin
            page_rd_reg <= page_mem[pn];
        end
    end

    assign rd_class = page_rd_reg[CLASS_W+WAY_W-1:WAY_W];
    assign rd_way   = page_rd_reg[WAY_W-1:0];

    // Tag store entries are valid, dirty and the full block address.
    assign hit = tag_rd_reg[TAG_ENT_W-1] && (tag_rd_reg[ADDR_W-1:0] == addr_reg);

    always_ff @(posedge aclk) begin
        if (clr_tag) begin
            tag_mem[clr_reg[TS_W-1:0]] <= '0;
        end else if (cmd.tag_check) begin
            tag_mem[slot_reg] <= {1'b1, (hit && tag_rd_reg[ADDR_W]) || wr_reg, addr_reg};
        end
        if (cmd.tag_read) begin
            tag_rd_reg <= tag_mem[slot];
            slot_reg   <= slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.place_a) begin
            sw_reg <= PLACE_W'(set_rem) * PLACE_W'(WAYS) + PLACE_W'(rd_way);
        end
        if (cmd.place_b) begin
            pre_reg <= sw_reg * PLACE_W'(BLOCKS_PER_HUGE) + PLACE_W'(off);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            res_reg <= '0;
        end else if (cmd.classify) begin
            if (rd_class == CLASS_UNIFORM) begin
                res_reg <= {1'b0, wr_reg};
            end else if (rd_class != CLASS_BLOAT) begin
                res_reg <= {1'b1, wr_reg};
            end
        end else if (cmd.tag_check) begin
            res_reg <= {!hit, wr_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_counters) begin
            uni_cnt_reg   <= '0;
            bloat_cnt_reg <= '0;
            cold_cnt_reg  <= '0;
            bhit_cnt_reg  <= '0;
        end else begin
            if (cmd.classify) begin
                if (rd_class == CLASS_UNIFORM) begin
                    uni_cnt_reg <= uni_cnt_reg + CNT_W'(1);
                end else if (rd_class == CLASS_BLOAT) begin
                    bloat_cnt_reg <= bloat_cnt_reg + CNT_W'(1);
                end else begin
                    cold_cnt_reg <= cold_cnt_reg + CNT_W'(1);
                end
            end
            if (cmd.tag_check && !direct_reg && hit) begin
                bhit_cnt_reg <= bhit_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= {6'd0, bhit_cnt_reg, cold_cnt_reg, bloat_cnt_reg, uni_cnt_reg, res_reg};
        end
    end

    assign m_axis_tdata      = out_reg;
    assign status.clear_last = (clr_reg == CLR_W'(CLR_N - 1));
    assign status.kind       = kind_reg;
    assign status.direct     = direct_reg;
    assign status.page_class = rd_class;

endmodule

`default_nettype wire

// ----- sv/dram_cache_access_lookup.sv -----
// DRAM cache access lookup: tag check of a direct-mapped DRAM cache with
// dirty bits and huge-page class placement.
//
// The input stream carries one item per handshake: an access (read or write by
// block address), a page class and way update, or a clear of the four coverage
// counters; the kind travels on s_axis_tuser. Every item gives one result item
// on the output stream: the access result and the four counters after the item.
// The cfg_we/cfg_wdata port writes the direct mode bit; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Items are worked on one at a time: a counter clear goes from dispatch to done, a
// page update waits on the dividers and writes the page table, a direct access
// reads and checks the tag store, a learned access reads the page table and
// classifies, and a bloat page is then placed and its tag read and checked. The
// constant dividers (two stages each) and the registered tag store and page
// table reads add wait states. The next item is taken in the idle state after
// done. A result waits in the output register while the receiver stalls, and
// the next item is accepted meanwhile; its own result waits until the register
// frees. After reset, s_axis_tready stays low while the tag store and page
// table are cleared one entry per cycle, over max(TAG_SLOTS, HUGE_PAGES) indices.
// Depends on dcal_pkg, dcal_ctrl, dcal_datapath and dcal_divc.
`default_nettype none

module dram_cache_access_lookup
    import dcal_pkg::*;
#(
    parameter int TAG_SLOTS       = 8192,
    parameter int BLOCKS_PER_HUGE = 64,
    parameter int WAYS            = 4,
    parameter int HUGE_PAGES      = 1024
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,      // direct_mode
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // is_write, block_address, page_number, page_class, way_slot, zero pad
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    input  wire logic [KIND_W-1:0]   s_axis_tuser,   // kind
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // access_result, uniform_count, bloat_count, cold_count, bloat_hit_count, zero pad
    output logic [M_DATA_W-1:0]      m_axis_tdata
);

    cmd_t    cmd;
    status_t status;

    dcal_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    dcal_datapath #(
        .TAG_SLOTS       (TAG_SLOTS),
        .BLOCKS_PER_HUGE (BLOCKS_PER_HUGE),
        .WAYS            (WAYS),
        .HUGE_PAGES      (HUGE_PAGES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .cmd          (cmd),
        .status       (status),
        .m_axis_tdata (m_axis_tdata)
    );

endmodule

`default_nettype wire
